@@ rtl/zvh_pkg.sv @@
// Shared types and constants of the zoomed value histogram unit.
// Used by zvh_cfg, zvh_addr, zoomed_value_histogram_unit and its testbench.
// No dependencies.
`timescale 1ns / 1ps

package zvh_pkg;

    // Default geometry
    localparam int BIN_BITS_DEF    = 10;
    localparam int BLOCKS_DEF      = 4;
    localparam int COUNT_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int VALUE_W    = 32;
    localparam int ALPHA_W    = 17;
    localparam int ZOOM_W     = 5;
    localparam int NBLK_W     = 3;
    localparam int SHIFT_W    = 6;
    localparam int IDX_W      = 12;
    localparam int KIND_W     = 2;
    localparam int OUT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = VALUE_W + ALPHA_W;
    localparam int SCALED_W   = PROD_W - FRAC_BITS;

    // Alpha of exactly one in Q1.16
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_Y_MIN       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ZOOM_LEVEL  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SCALE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_EN   = CFG_IDX_W'(4);

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE   = 2'd0,
        KIND_READ     = 2'd1,
        KIND_READ_CLR = 2'd2
    } kind_t;

    // Effective (saturated) configuration
    typedef struct packed {
        logic [VALUE_W-1:0] y_min;
        logic [SHIFT_W-1:0] shift;
        logic [ALPHA_W-1:0] alpha;
        logic [NBLK_W-1:0]  nblk;
        logic               sel_en;
    } cfg_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_ADDR,
        ST_UPD
    } state_t;

endpackage

@@ rtl/zvh_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module zvh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/zvh_cfg.sv @@
// Configuration registers; stores y_min, select enable and the saturated zoom shift, alpha and block count.
// Depends on zvh_pkg.
`timescale 1ns / 1ps

module zvh_cfg #(
    parameter int BIN_BITS = zvh_pkg::BIN_BITS_DEF,
    parameter int BLOCKS   = zvh_pkg::BLOCKS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [zvh_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [zvh_pkg::CFG_DATA_W-1:0]      wr_data,
    output zvh_pkg::cfg_t                       cfg
);

    localparam logic [zvh_pkg::ZOOM_W-1:0] ZOOM_MAX =
        zvh_pkg::ZOOM_W'(zvh_pkg::VALUE_W - BIN_BITS);
    localparam logic [zvh_pkg::SHIFT_W-1:0] SHIFT_FULL =
        zvh_pkg::SHIFT_W'(zvh_pkg::VALUE_W);

    zvh_pkg::cfg_t cfg_reg;
    zvh_pkg::cfg_t cfg_next;

    logic [zvh_pkg::ZOOM_W-1:0]  zoom_in;
    logic [zvh_pkg::ZOOM_W-1:0]  zoom_eff;
    logic [zvh_pkg::NBLK_W-1:0]  nblk_in;
    logic [zvh_pkg::ALPHA_W-1:0] alpha_in;

    // Slice the incoming fields and saturate the zoom level
    always_comb
    begin
        zoom_in  = wr_data[zvh_pkg::ZOOM_W-1:0];
        zoom_eff = (zoom_in > ZOOM_MAX) ? ZOOM_MAX : zoom_in;
        nblk_in  = wr_data[zvh_pkg::NBLK_W-1:0];
        alpha_in = wr_data[zvh_pkg::ALPHA_W-1:0];
    end

    // Register update
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                zvh_pkg::REG_Y_MIN:
                begin
                    cfg_next.y_min = wr_data[zvh_pkg::VALUE_W-1:0];
                end
                zvh_pkg::REG_ZOOM_LEVEL:
                begin
                    cfg_next.shift = SHIFT_FULL - zvh_pkg::SHIFT_W'(zoom_eff);
                end
                zvh_pkg::REG_ALPHA_SCALE:
                begin
                    cfg_next.alpha = (alpha_in > zvh_pkg::ALPHA_ONE) ?
                                     zvh_pkg::ALPHA_ONE : alpha_in;
                end
                zvh_pkg::REG_BLOCK_COUNT:
                begin
                    cfg_next.nblk = (int'(nblk_in) > BLOCKS) ?
                                    zvh_pkg::NBLK_W'(BLOCKS) : nblk_in;
                end
                zvh_pkg::REG_SELECT_EN:
                begin
                    cfg_next.sel_en = wr_data[0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.y_min  <= '0;
            cfg_reg.shift  <= SHIFT_FULL;
            cfg_reg.alpha  <= zvh_pkg::ALPHA_ONE;
            cfg_reg.nblk   <= zvh_pkg::NBLK_W'(1);
            cfg_reg.sel_en <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/zvh_addr.sv @@
// Sample binning datapath: window check, alpha scaling (registered product)
// and counter address. Depends on zvh_pkg.
`timescale 1ns / 1ps

module zvh_addr #(
    parameter int BIN_BITS = zvh_pkg::BIN_BITS_DEF,
    parameter int BLOCKS   = zvh_pkg::BLOCKS_DEF,
    parameter int ADDR_W   = $clog2(BLOCKS * (2 ** BIN_BITS))
) (
    input  logic                          clk,
    input  logic                          load,
    input  zvh_pkg::cfg_t                 cfg,
    input  logic [zvh_pkg::VALUE_W-1:0]   value,
    input  logic                          selected,
    output logic [ADDR_W-1:0]             addr,
    output logic                          addr_ok
);

    localparam int WIDE_W = zvh_pkg::SCALED_W + BIN_BITS;

    logic [zvh_pkg::VALUE_W-1:0]  value_hi;
    logic [zvh_pkg::VALUE_W-1:0]  base;
    logic [zvh_pkg::VALUE_W-1:0]  ref_val;
    logic [zvh_pkg::VALUE_W-1:0]  offset;
    logic [zvh_pkg::VALUE_W-1:0]  diff;
    logic                         keep;
    logic [zvh_pkg::PROD_W-1:0]   prod_next;
    logic [zvh_pkg::PROD_W-1:0]   prod_reg;
    logic                         keep_reg;
    logic [zvh_pkg::SCALED_W-1:0] scaled;
    logic [zvh_pkg::SCALED_W-1:0] blk;
    logic [zvh_pkg::SCALED_W-1:0] bin_sh;
    logic [zvh_pkg::SHIFT_W-1:0]  bin_shift;
    logic [WIDE_W-1:0]            wide_addr;

    // Window check and offset from the aligned base
    always_comb
    begin
        value_hi = value >> cfg.shift;
        base     = cfg.y_min >> cfg.shift;
        ref_val  = base << cfg.shift;
        offset   = value_hi - base;
        keep     = !(cfg.sel_en && !selected) && (value_hi >= base) &&
                   (offset < zvh_pkg::VALUE_W'(cfg.nblk));
        diff     = value - ref_val;
        prod_next = zvh_pkg::PROD_W'(diff) * zvh_pkg::PROD_W'(cfg.alpha);
    end

    // Product register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
            keep_reg <= keep;
        end
    end

    // Block and bin from the scaled value
    always_comb
    begin
        scaled    = prod_reg[zvh_pkg::PROD_W-1:zvh_pkg::FRAC_BITS];
        blk       = scaled >> cfg.shift;
        bin_shift = cfg.shift - zvh_pkg::SHIFT_W'(BIN_BITS);
        bin_sh    = scaled >> bin_shift;
        wide_addr = {blk, bin_sh[BIN_BITS-1:0]};
        addr      = wide_addr[ADDR_W-1:0];
        addr_ok   = keep_reg && (blk < zvh_pkg::SCALED_W'(BLOCKS));
    end

endmodule

@@ rtl/zoomed_value_histogram_unit.sv @@
// Top level of the zoomed value histogram unit: sequencer, counter memory,
// configuration and binning datapath. Depends on zvh_pkg, zvh_ram, zvh_cfg, zvh_addr.
`timescale 1ns / 1ps

// After reset the unit sweeps the counter memory to zero, one entry per cycle,
// and holds busy high during the sweep; configuration writes are taken during
// the sweep. An item is taken when start is high and busy is low. The counters
// live in one RAM with a registered read, and each item works on at most one
// entry, so one item is in flight: a counted sample steps through ST_MUL, ST_ADDR
// and ST_UPD, a read through ST_ADDR and ST_UPD, a dropped sample through ST_MUL
// and ST_ADDR, an out-of-range read through ST_ADDR only, and an unused kind
// stays in ST_IDLE. Each read item gives one result: done pulses for one cycle
// with bin_count, registered from ST_UPD (from ST_ADDR when out of range). The
// receiver cannot stall, so bin_count must be captured in the cycle done is high.
module zoomed_value_histogram_unit #(
    parameter int BIN_BITS    = zvh_pkg::BIN_BITS_DEF,
    parameter int BLOCKS      = zvh_pkg::BLOCKS_DEF,
    parameter int COUNT_WIDTH = zvh_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [zvh_pkg::KIND_W-1:0]       kind,
    input  logic [zvh_pkg::VALUE_W-1:0]      sample_value,
    input  logic                             selected,
    input  logic [zvh_pkg::IDX_W-1:0]        bin_index,
    output logic                             done,
    output logic [zvh_pkg::OUT_W-1:0]        bin_count,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [zvh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [zvh_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int DEPTH  = BLOCKS * (2 ** BIN_BITS);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    zvh_pkg::state_t state_reg;
    zvh_pkg::state_t state_next;
    zvh_pkg::cfg_t   cfg;

    logic [ADDR_W-1:0]              clr_cnt_reg;
    logic [ADDR_W-1:0]              clr_cnt_next;
    logic [zvh_pkg::KIND_W-1:0]     kind_reg;
    logic [zvh_pkg::VALUE_W-1:0]    value_reg;
    logic                           sel_reg;
    logic [zvh_pkg::IDX_W-1:0]      idx_reg;
    logic                           done_reg;
    logic                           done_next;
    logic [zvh_pkg::OUT_W-1:0]      bin_count_reg;
    logic [zvh_pkg::OUT_W-1:0]      bin_count_next;

    logic                           accept;
    logic                           is_sample;
    logic                           idx_ok;
    logic [ADDR_W-1:0]              smp_addr;
    logic                           smp_ok;
    logic [ADDR_W-1:0]              cur_addr;
    logic                           cur_ok;
    logic                           mul_load;

    logic                           ram_we;
    logic [ADDR_W-1:0]              ram_waddr;
    logic [COUNT_WIDTH-1:0]         ram_wdata;
    logic                           ram_re;
    logic [COUNT_WIDTH-1:0]         ram_rdata;

    // Configuration registers
    zvh_cfg #(
        .BIN_BITS (BIN_BITS),
        .BLOCKS   (BLOCKS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign cfg_ready = 1'b1;

    // Binning datapath
    zvh_addr #(
        .BIN_BITS (BIN_BITS),
        .BLOCKS   (BLOCKS),
        .ADDR_W   (ADDR_W)
    ) u_addr (
        .clk      (clk),
        .load     (mul_load),
        .cfg      (cfg),
        .value    (value_reg),
        .selected (sel_reg),
        .addr     (smp_addr),
        .addr_ok  (smp_ok)
    );

    // Counter memory
    zvh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cur_addr),
        .rdata (ram_rdata)
    );

    // Item decode and current address
    always_comb
    begin
        accept    = start && !busy;
        is_sample = (kind_reg == zvh_pkg::KIND_SAMPLE);
        idx_ok    = (32'(idx_reg) < 32'(DEPTH));
        cur_addr  = is_sample ? smp_addr : ADDR_W'(idx_reg);
        cur_ok    = is_sample ? smp_ok : idx_ok;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            zvh_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = zvh_pkg::ST_IDLE;
                end
            end
            zvh_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        zvh_pkg::KIND_SAMPLE:   state_next = zvh_pkg::ST_MUL;
                        zvh_pkg::KIND_READ,
                        zvh_pkg::KIND_READ_CLR: state_next = zvh_pkg::ST_ADDR;
                        default:                state_next = zvh_pkg::ST_IDLE;
                    endcase
                end
            end
            zvh_pkg::ST_MUL:
            begin
                state_next = zvh_pkg::ST_ADDR;
            end
            zvh_pkg::ST_ADDR:
            begin
                state_next = cur_ok ? zvh_pkg::ST_UPD : zvh_pkg::ST_IDLE;
            end
            zvh_pkg::ST_UPD:
            begin
                state_next = zvh_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = zvh_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        mul_load       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = cur_addr;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        done_next      = 1'b0;
        bin_count_next = bin_count_reg;
        case (state_reg)
            zvh_pkg::ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            end
            zvh_pkg::ST_MUL:
            begin
                mul_load = 1'b1;
            end
            zvh_pkg::ST_ADDR:
            begin
                ram_re = cur_ok;
                // read beyond the histogram answers zero
                if (!is_sample && !cur_ok)
                begin
                    done_next      = 1'b1;
                    bin_count_next = '0;
                end
            end
            zvh_pkg::ST_UPD:
            begin
                if (is_sample)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata + COUNT_WIDTH'(1);
                end
                else
                begin
                    ram_we         = (kind_reg == zvh_pkg::KIND_READ_CLR);
                    done_next      = 1'b1;
                    bin_count_next = zvh_pkg::OUT_W'(ram_rdata);
                end
            end
            default:
            begin
                clr_cnt_next = clr_cnt_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= zvh_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    // Item capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind;
            value_reg <= sample_value;
            sel_reg   <= selected;
            idx_reg   <= bin_index;
        end
        bin_count_reg <= bin_count_next;
    end

    assign busy      = (state_reg != zvh_pkg::ST_IDLE);
    assign done      = done_reg;
    assign bin_count = bin_count_reg;

endmodule

@@ test/zoomed_value_histogram_unit_tb.sv @@
// Self-checking testbench for zoomed_value_histogram_unit: directed and random items
// scored by a built-in binning predictor. Depends on zvh_pkg and the unit's RTL.
`timescale 1ns / 1ps

module zoomed_value_histogram_unit_tb;
    import zvh_pkg::*;

    localparam int BIN_BITS      = BIN_BITS_DEF;
    localparam int BLOCKS        = BLOCKS_DEF;
    localparam int DEPTH         = BLOCKS << BIN_BITS;
    localparam int MAX_ZOOM      = 32 - BIN_BITS;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 1930;
    localparam int RANDOM_PHASES = 8;
    localparam int TIMEOUT_NS    = 1_000_000;

    localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [KIND_W-1:0]     kind;
    logic [VALUE_W-1:0]    sample_value;
    logic                  selected;
    logic [IDX_W-1:0]      bin_index;
    logic                  done;
    logic [OUT_W-1:0]      bin_count;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor state: counters and raw register copies
    bit [31:0] counts_model [DEPTH];
    bit [31:0] y_min_r;
    bit [4:0]  zoom_r;
    bit [16:0] alpha_r;
    bit [2:0]  nblk_r;
    bit        sel_en_r;

    bit [31:0] expected_counts [$];
    bit [31:0] want;
    int        last_hit;
    int        idle_pct;
    int        err_count;

    zoomed_value_histogram_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .sample_value (sample_value),
        .selected     (selected),
        .bin_index    (bin_index),
        .done         (done),
        .bin_count    (bin_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        err_count++;
    endtask

    // Effective window shift after zoom saturation
    function automatic int eff_shift();
        return 32 - ((zoom_r > MAX_ZOOM) ? MAX_ZOOM : int'(zoom_r));
    endfunction

    function automatic int eff_blocks();
        return (nblk_r > BLOCKS) ? BLOCKS : int'(nblk_r);
    endfunction

    // Bin one sample into the counter model
    function automatic void count_sample(input bit [31:0] v, input bit sel);
        int        sh;
        bit [63:0] base;
        bit [63:0] lo;
        bit [63:0] hi_part;
        bit [63:0] alpha;
        bit [63:0] scaled;
        bit [63:0] blk;
        bit [63:0] bin;
        bit [63:0] addr;
        if (sel_en_r && !sel)
            return;
        sh      = eff_shift();
        base    = 64'(y_min_r) >> sh;
        lo      = base << sh;
        hi_part = 64'(v) >> sh;
        if (hi_part < base || (hi_part - base) >= 64'(eff_blocks()))
            return;
        alpha  = (alpha_r > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(alpha_r);
        scaled = ((64'(v) - lo) * alpha) >> FRAC_BITS;
        blk    = scaled >> sh;
        bin    = (scaled & ((64'd1 << sh) - 64'd1)) >> (sh - BIN_BITS);
        addr   = (blk << BIN_BITS) | bin;
        if (addr >= DEPTH)
            return;
        counts_model[addr] = counts_model[addr] + 32'd1;
        last_hit = int'(addr);
    endfunction

    // Update the model for one accepted item and queue any read result
    function automatic void predict_item(input logic [KIND_W-1:0] k, input bit [31:0] v,
                                         input bit sel, input bit [IDX_W-1:0] idx);
        case (k)
            KIND_SAMPLE:
                count_sample(v, sel);
            KIND_READ, KIND_READ_CLR:
            begin
                if (idx >= DEPTH)
                    expected_counts.push_back(32'd0);
                else
                begin
                    expected_counts.push_back(counts_model[idx]);
                    if (k == KIND_READ_CLR)
                        counts_model[idx] = 32'd0;
                end
            end
            default: ;
        endcase
    endfunction

    // One item transfer; random idle cycles ahead of it per idle_pct
    task automatic send_item(input logic [KIND_W-1:0] k, input bit [31:0] v,
                             input bit sel, input bit [IDX_W-1:0] idx);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start        = 1'b1;
        kind         = k;
        sample_value = v;
        selected     = sel;
        bin_index    = idx;
        do
            @(posedge clk);
        while (busy);
        predict_item(k, v, sel, idx);
    endtask

    // Stop sending and let every pending result and counter update finish
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (expected_counts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [31:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_Y_MIN:       y_min_r  = data;
            REG_ZOOM_LEVEL:  zoom_r   = data[4:0];
            REG_ALPHA_SCALE: alpha_r  = data[16:0];
            REG_BLOCK_COUNT: nblk_r   = data[2:0];
            REG_SELECT_EN:   sel_en_r = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input bit [31:0] y, input bit [31:0] z, input bit [31:0] a,
                              input bit [31:0] n, input bit [31:0] s);
        drain();
        write_reg(REG_Y_MIN, y);
        write_reg(REG_ZOOM_LEVEL, z);
        write_reg(REG_ALPHA_SCALE, a);
        write_reg(REG_BLOCK_COUNT, n);
        write_reg(REG_SELECT_EN, s);
    endtask

    // Result checker: done is a one-cycle strobe, no back-pressure
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (expected_counts.size() == 0)
                report_mismatch($sformatf("unexpected result bin_count=%08h", bin_count));
            else
            begin
                want = expected_counts.pop_front();
                if (bin_count !== want)
                    report_mismatch($sformatf("bin_count %08h, expected %08h",
                                              bin_count, want));
            end
        end
    end

    // Reset register values, full-range extremes, unused kind
    task automatic test_defaults();
        send_item(KIND_READ, 32'h0, 1'b0, 12'd0);
        send_item(KIND_SAMPLE, 32'h0, 1'b0, 12'd0);
        send_item(KIND_SAMPLE, 32'hFFFF_FFFF, 1'b1, 12'hFFF);
        send_item(KIND_UNUSED, 32'h5A5A_5A5A, 1'b1, 12'hA5A);
        send_item(KIND_READ_CLR, 32'h0, 1'b0, 12'd1023);
        send_item(KIND_READ, 32'h0, 1'b0, 12'd0);
        send_item(KIND_READ, 32'h0, 1'b0, 12'd1023);
    endtask

    // Zoom, alpha and block count above range, window edges
    task automatic test_window_saturation();
        set_config(32'h8000_1234, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_item(KIND_SAMPLE, 32'h8000_1000, 1'b0, 12'd0);
        send_item(KIND_SAMPLE, 32'h8000_1FFF, 1'b0, 12'd0);
        send_item(KIND_SAMPLE, 32'h8000_2000, 1'b1, 12'd0);
        send_item(KIND_SAMPLE, 32'h8000_0FFF, 1'b1, 12'd0);
        send_item(KIND_READ_CLR, 32'h0, 1'b0, 12'd4095);
        send_item(KIND_READ, 32'h0, 1'b0, 12'd0);
    endtask

    // Alpha zero, selection filter, block count zero, unmapped registers
    task automatic test_alpha_zero_select();
        set_config(32'hFFFF_FFFF, 32'd16, 32'd0, 32'd2, 32'd1);
        send_item(KIND_SAMPLE, 32'hFFFF_ABCD, 1'b1, 12'd0);
        send_item(KIND_SAMPLE, 32'hFFFF_0001, 1'b0, 12'd0);
        send_item(KIND_READ_CLR, 32'h0, 1'b0, 12'd0);
        drain();
        write_reg(REG_BLOCK_COUNT, 32'd0);
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_HI, 32'h1234_5678);
        send_item(KIND_SAMPLE, 32'hFFFF_0000, 1'b1, 12'd0);
        send_item(KIND_READ, 32'h0, 1'b0, 12'd0);
    endtask

    // Mostly in-window samples, with reads biased toward recently hit bins
    task automatic send_random_item();
        int               r;
        int               sh;
        bit [63:0]        lo;
        bit [63:0]        span;
        bit [63:0]        off;
        bit [IDX_W-1:0]   idx;
        bit               sel;
        r = $urandom_range(99);
        if (r < 2)
            send_item(KIND_UNUSED, $urandom, 1'($urandom_range(1)), IDX_W'($urandom));
        else if (r < 22)
        begin
            case ($urandom_range(3))
                0, 1: idx = IDX_W'(last_hit);
                2:    idx = IDX_W'($urandom);
                default:
                    idx = IDX_W'($urandom_range(0, (eff_blocks() << BIN_BITS) - 1));
            endcase
            send_item((r < 12) ? KIND_READ : KIND_READ_CLR, $urandom,
                      1'($urandom_range(1)), idx);
        end
        else if (r < 32)
            send_item(KIND_SAMPLE, $urandom, 1'($urandom_range(1)), IDX_W'($urandom));
        else
        begin
            sh   = eff_shift();
            lo   = (64'(y_min_r) >> sh) << sh;
            span = 64'(eff_blocks()) << sh;
            case ($urandom_range(9))
                0:       off = 64'd0;
                1:       off = span - 64'd1;
                default: off = {$urandom, $urandom} % span;
            endcase
            sel = ($urandom_range(9) != 0);
            send_item(KIND_SAMPLE, 32'(lo + off), sel, IDX_W'($urandom));
        end
    endtask

    // Random traffic over several register settings and idle patterns
    task automatic test_random_phases();
        int pct_table [4] = '{0, 51, 0, 6};
        bit [31:0] a;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            idle_pct = 0;
            case (phase)
                0: set_config(32'h0, 32'd0, 32'd65536, 32'd1, 32'd0);
                1: set_config(32'hFFFF_FFFF, 32'd22, 32'd65536, 32'd4, 32'd1);
                2: set_config($urandom, 32'd22, 32'd1, 32'd4, 32'd0);
                default:
                begin
                    case ($urandom_range(3))
                        0:       a = 32'd65536;
                        1:       a = $urandom_range(1, 65536);
                        2:       a = $urandom_range(32768, 65536);
                        default: a = $urandom_range(65537, 131071);
                    endcase
                    set_config($urandom, $urandom_range(0, 24), a,
                               $urandom_range(1, 7), $urandom_range(1));
                end
            endcase
            idle_pct = pct_table[phase % 4];
            for (int i = 0; i < RANDOM_ITEMS / RANDOM_PHASES; i++)
            begin
                // occasional hold-off until the unit has gone quiet
                if ($urandom_range(99) == 0)
                    drain();
                send_random_item();
            end
        end
        idle_pct = 0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        kind         = KIND_SAMPLE;
        sample_value = '0;
        selected     = 1'b0;
        bin_index    = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_Y_MIN;
        cfg_data     = '0;
        y_min_r      = 32'd0;
        zoom_r       = 5'd0;
        alpha_r      = 17'd65536;
        nblk_r       = 3'd1;
        sel_en_r     = 1'b0;
        last_hit     = 0;
        idle_pct     = 0;
        err_count    = 0;
        foreach (counts_model[i])
            counts_model[i] = 32'd0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_defaults();
        test_window_saturation();
        test_alpha_zero_select();
        test_random_phases();
        drain();

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/zvh_pkg.sv
rtl/zvh_ram.sv
rtl/zvh_cfg.sv
rtl/zvh_addr.sv
rtl/zoomed_value_histogram_unit.sv
test/zoomed_value_histogram_unit_tb.sv
